// File: design/bms_info_frame_checker_core_defines.svh
// Assertion macros for the battery info frame checker.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef BMS_INFO_FRAME_CHECKER_CORE_DEFINES_SVH
`define BMS_INFO_FRAME_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BIFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BIFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bifc_pkg.sv
// Package for the battery info frame checker: frame constants, record layout,
// and the record slot decode. No dependencies.
`timescale 1ns / 1ps

package bifc_pkg;

    localparam int FRAME_LEN    = 34;
    localparam int LEN_OVERHEAD = 7;
    localparam int POS_MAX      = 63;
    localparam int POS_W        = 6;
    localparam int END_W        = 9;
    localparam int REC_BYTES    = 11;
    localparam int SLOT_W       = 4;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_slot;

    // record bytes: 4..11 -> 0..7, 20 -> 8, 21 -> 9, 23 -> 10
    function automatic t_slot rec_slot(input logic [POS_W-1:0] pos);
        t_slot s;
        s.hit = 1'b1;
        s.idx = '0;
        if (pos >= POS_W'(4) && pos <= POS_W'(11)) begin
            s.idx = SLOT_W'(pos - POS_W'(4));
        end else if (pos == POS_W'(20)) begin
            s.idx = SLOT_W'(8);
        end else if (pos == POS_W'(21)) begin
            s.idx = SLOT_W'(9);
        end else if (pos == POS_W'(23)) begin
            s.idx = SLOT_W'(10);
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

// File: design/bifc_in_if.sv
// Byte request channel of the battery info frame checker.
// Standalone; valid/ready handshake.
`timescale 1ns / 1ps

interface bifc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, rx_byte, end_of_frame, input ready);
    modport sink   (input valid, rx_byte, end_of_frame, output ready);
endinterface

// File: design/bifc_out_if.sv
// Result request channel of the battery info frame checker.
// Standalone; valid/ready handshake.
`timescale 1ns / 1ps

interface bifc_out_if;
    logic        valid;
    logic        ready;
    logic        frame_accepted;
    logic        record_held;
    logic [15:0] pack_voltage;
    logic [15:0] pack_current;
    logic [15:0] remaining_capacity;
    logic [15:0] nominal_capacity;
    logic [15:0] protection_status;
    logic [7:0]  charge_percent;

    modport source (output valid, frame_accepted, record_held, pack_voltage, pack_current,
                    remaining_capacity, nominal_capacity, protection_status,
                    charge_percent, input ready);
    modport sink   (input valid, frame_accepted, record_held, pack_voltage, pack_current,
                    remaining_capacity, nominal_capacity, protection_status,
                    charge_percent, output ready);
endinterface

// File: design/bms_info_frame_checker_core.sv
// Battery info frame checker. The end-of-frame byte request is registered in
// the input register, then its result in the output register. 1 byte request
// per cycle sustained, set by the single per-byte sum/capture stage. A result
// waiting in the output register stalls only a further end-of-frame byte.
// Synchronous active-low reset clears the frame state, the held record (fields
// read zero) and the record-held flag. Uses bifc_pkg, bifc_in_if, bifc_out_if.
`timescale 1ns / 1ps

module bms_info_frame_checker_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bifc_in_if.sink            i_in,
    bifc_out_if.source         o_out
);

    localparam logic [bifc_pkg::POS_W:0]   LenLast = (bifc_pkg::POS_W + 1)'(bifc_pkg::FRAME_LEN);
    localparam logic [bifc_pkg::END_W-1:0] EndMin  = bifc_pkg::END_W'(bifc_pkg::LEN_OVERHEAD);
    localparam logic [bifc_pkg::END_W-1:0] EndMax  = bifc_pkg::END_W'(bifc_pkg::FRAME_LEN);
    localparam logic [bifc_pkg::POS_W-1:0] PosMax  = bifc_pkg::POS_W'(bifc_pkg::POS_MAX);

    // input register
    logic                r_s1_valid;
    bifc_pkg::t_byte     r_s1_byte;
    logic                r_s1_eof;

    // frame state
    logic [bifc_pkg::POS_W-1:0] r_pos,  n_pos;
    logic [bifc_pkg::END_W-1:0] r_cend, n_cend;
    logic [15:0]                r_sum,  n_sum;
    logic [15:0]                r_cks,  n_cks;
    bifc_pkg::t_byte            r_pend [bifc_pkg::REC_BYTES];
    bifc_pkg::t_byte            n_pend [bifc_pkg::REC_BYTES];
    bifc_pkg::t_byte            r_held [bifc_pkg::REC_BYTES];
    logic                       r_flag;

    // result register
    logic                r_out_valid;
    logic                r_out_ok;

    logic                out_free;
    logic                s1_consume;
    logic                in_accept;
    logic                ok;
    bifc_pkg::t_slot     slot;
    logic [bifc_pkg::END_W:0] pos_p3, pos_p2, cend_x;

    always_comb begin
        out_free   = !r_out_valid || o_out.ready;
        s1_consume = r_s1_valid && (!r_s1_eof || out_free);
        i_in.ready = !r_s1_valid || s1_consume;
        in_accept  = i_in.valid && i_in.ready;
    end

    always_comb begin
        n_pos  = (r_pos < PosMax) ? r_pos + 1'b1 : r_pos;
        n_cend = r_cend;
        n_sum  = r_sum;
        n_cks  = r_cks;
        pos_p3 = (bifc_pkg::END_W + 1)'(r_pos) + (bifc_pkg::END_W + 1)'(3);
        pos_p2 = (bifc_pkg::END_W + 1)'(r_pos) + (bifc_pkg::END_W + 1)'(2);
        cend_x = {1'b0, r_cend};
        if (r_pos == bifc_pkg::POS_W'(2)) begin
            n_sum = r_sum + {8'd0, r_s1_byte};
        end else if (r_pos == bifc_pkg::POS_W'(3)) begin
            n_sum  = r_sum + {8'd0, r_s1_byte};
            n_cend = {1'b0, r_s1_byte} + EndMin;
        end else if (r_pos >= bifc_pkg::POS_W'(4)) begin
            if (pos_p3 < cend_x) begin
                n_sum = r_sum + {8'd0, r_s1_byte};
            end else if (pos_p3 == cend_x) begin
                n_cks = {r_s1_byte, r_cks[7:0]};
            end else if (pos_p2 == cend_x) begin
                n_cks = {r_cks[15:8], r_s1_byte};
            end
        end

        slot = bifc_pkg::rec_slot(r_pos);
        for (int k = 0; k < bifc_pkg::REC_BYTES; k++) begin
            n_pend[k] = (slot.hit && slot.idx == bifc_pkg::SLOT_W'(k)) ? r_s1_byte : r_pend[k];
        end

        ok = ({1'b0, r_pos} + 1'b1 == LenLast) && (r_pos < PosMax)
             && (n_cend >= EndMin) && (n_cend <= EndMax)
             && ((16'd0 - n_sum) == n_cks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_cend      <= '0;
            r_sum       <= '0;
            r_cks       <= '0;
            r_flag      <= 1'b0;
            for (int k = 0; k < bifc_pkg::REC_BYTES; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !s1_consume);
            if (s1_consume && r_s1_eof) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_consume) begin
                if (r_s1_eof) begin
                    r_pos  <= '0;
                    r_cend <= '0;
                    r_sum  <= '0;
                    r_cks  <= '0;
                    if (ok) begin
                        r_flag <= 1'b1;
                        r_held <= n_pend;
                    end
                end else begin
                    r_pos  <= n_pos;
                    r_cend <= n_cend;
                    r_sum  <= n_sum;
                    r_cks  <= n_cks;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_in.rx_byte;
            r_s1_eof  <= i_in.end_of_frame;
        end
        if (s1_consume) begin
            r_pend <= n_pend;
        end
        if (s1_consume && r_s1_eof) begin
            r_out_ok <= ok;
        end
    end

    // held record only changes when a new result loads, so it drives the fields
    always_comb begin
        o_out.valid              = r_out_valid;
        o_out.frame_accepted     = r_out_ok;
        o_out.record_held        = r_flag;
        o_out.pack_voltage       = {r_held[0], r_held[1]};
        o_out.pack_current       = {r_held[2], r_held[3]};
        o_out.remaining_capacity = {r_held[4], r_held[5]};
        o_out.nominal_capacity   = {r_held[6], r_held[7]};
        o_out.protection_status  = {r_held[8], r_held[9]};
        o_out.charge_percent     = r_held[10];
    end

endmodule

// File: design/bifc_checker.sv
// Port-level checks for the battery info frame checker, bound to the top level.
// Uses bms_info_frame_checker_core_defines.svh.
`timescale 1ns / 1ps
`include "bms_info_frame_checker_core_defines.svh"

module bifc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_frame_accepted,
    input  logic        i_record_held,
    input  logic [15:0] i_pack_voltage,
    input  logic [15:0] i_pack_current,
    input  logic [15:0] i_remaining_capacity,
    input  logic [15:0] i_nominal_capacity,
    input  logic [15:0] i_protection_status,
    input  logic [7:0]  i_charge_percent
);

    `BIFC_ASSERT_NOW(a_accept_sets_flag, i_out_valid && i_frame_accepted, i_record_held, "accepted frame without record flag")
    `BIFC_ASSERT_NEXT(a_flag_sticks, i_record_held, i_record_held, "record flag dropped")
    `BIFC_ASSERT_NOW(a_empty_is_zero, !i_record_held, i_pack_voltage == 16'd0 && i_pack_current == 16'd0 && i_remaining_capacity == 16'd0 && i_nominal_capacity == 16'd0 && i_protection_status == 16'd0 && i_charge_percent == 8'd0, "fields set with no record held")
    `BIFC_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_frame_accepted) && $stable(i_pack_voltage) && $stable(i_charge_percent), "stalled result changed")

endmodule

bind bms_info_frame_checker_core bifc_checker u_bifc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_frame_accepted     (o_out.frame_accepted),
    .i_record_held        (o_out.record_held),
    .i_pack_voltage       (o_out.pack_voltage),
    .i_pack_current       (o_out.pack_current),
    .i_remaining_capacity (o_out.remaining_capacity),
    .i_nominal_capacity   (o_out.nominal_capacity),
    .i_protection_status  (o_out.protection_status),
    .i_charge_percent     (o_out.charge_percent)
);
